@@ rtl/bandpass_window_area_kurtosis_defines.svh @@
// assertion macros for the band-pass window area and kurtosis block
`ifndef BANDPASS_WINDOW_AREA_KURTOSIS_DEFINES_SVH
`define BANDPASS_WINDOW_AREA_KURTOSIS_DEFINES_SVH

// checked while out of reset
`define BWAK_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define BWAK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/bwak_pkg.sv @@
// shared types, constants and helpers for the band-pass window area and kurtosis block
`default_nettype none
package bwak_pkg;

    localparam int COEF_FRAC = 29;
    localparam int ACC_W     = 40;
    localparam int Y_W       = 24;
    localparam int MEAN_W    = 25;
    localparam int D_W       = 26;
    localparam int DQ_W      = 112;
    localparam int DEN_W     = 96;
    localparam int REM_W     = 97;
    localparam int DCNT_W    = 7;

    localparam logic [23:0] KURT_MAX = 24'hFF_FFFF;
    localparam logic [39:0] AREA_MAX = 40'hFF_FFFF_FFFF;

    localparam logic [2:0] REG_SECTION_COUNT  = 3'd0;
    localparam logic [2:0] REG_WINDOW_LENGTH  = 3'd1;
    localparam logic [2:0] REG_AREA_SCALE     = 3'd2;
    localparam logic [2:0] REG_CHANNEL_SELECT = 3'd3;
    localparam logic [2:0] REG_COEF_WRITE     = 3'd4;

    localparam logic [1:0] CH_A = 2'd0;
    localparam logic [1:0] CH_B = 2'd1;

    localparam logic [2:0] TERM_B0 = 3'd0;
    localparam logic [2:0] TERM_B1 = 3'd1;
    localparam logic [2:0] TERM_B2 = 3'd2;
    localparam logic [2:0] TERM_A1 = 3'd3;
    localparam logic [2:0] TERM_A2 = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_C_RD0,
        ST_C_M0,
        ST_C_Y,
        ST_C_T1,
        ST_C_T2,
        ST_C_T3,
        ST_C_T4,
        ST_C_OUT,
        ST_W_AREA0,
        ST_W_AREA1,
        ST_W_AREA2,
        ST_DIV,
        ST_DIV_END,
        ST_P_D,
        ST_P_E,
        ST_P_M,
        ST_K_SQ0,
        ST_K_SQ1,
        ST_K_SQ2,
        ST_K_SQ3,
        ST_W_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_MEAN,
        OP_M2,
        OP_M4,
        OP_KURT
    } divop_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF};
        lo = {{(ACC_W-32){1'b1}}, 32'h8000_0000};
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/bandpass_window_area_kurtosis.sv @@
// top level: biquad cascade, window store, area and kurtosis over a shared multiplier and divider
//
//  channel | ports                                  | role
//  input   | s_valid s_ready s_sample_a s_sample_b  | one beat per sample pair
//  result  | m_valid m_ready m_window_number ...    | one beat per closed window
//  config  | psel penable pwrite paddr pwdata ...   | register writes and reads
//
// a sample passes through the S active sections in turn, S the active section count, all on the one multiplier
// a window close runs the serial divider (one quotient bit a cycle) for the mean and, unless the
// window is flat, the moments and the kurtosis, with one pass over the store through its read port
// reset is synchronous active low; the filter delays start at zero and no clearing pass runs
// a result waiting in the output register blocks only the next window close
`default_nettype none
`include "bandpass_window_area_kurtosis_defines.svh"
module bandpass_window_area_kurtosis
    import bwak_pkg::*;
#(
    parameter int MAX_SECTIONS = 8,
    parameter int WINDOW_MAX   = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_sample_a,
    input  logic signed [15:0] s_sample_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_window_number,
    output logic [39:0]        m_area,
    output logic [23:0]        m_kurtosis,
    output logic               m_flat_window,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam int COEF_COUNT = 5 * MAX_SECTIONS;
    localparam int CIDX_W = $clog2(COEF_COUNT);
    localparam int SEC_W  = $clog2(MAX_SECTIONS + 1);
    localparam int SIDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int WIDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int LC_W   = (CNT_W > 13) ? CNT_W + 1 : 14;
    localparam int A_W    = WIDX_W + 24;
    localparam int SUM_W  = WIDX_W + 25;
    localparam int MUL_W  = (A_W + 1 > 33) ? A_W + 1 : 33;
    localparam int AR_W   = A_W + 17;
    localparam int S2_W   = 48 + WIDX_W;
    localparam int M4_W   = 64 + WIDX_W;

    // configuration registers
    logic [3:0]  sc_reg;
    logic [12:0] wl_reg;
    logic [31:0] as_reg;
    logic [1:0]  cs_reg;
    logic [37:0] cw_reg;

    logic cfg_wr;
    logic coef_we;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign coef_we = cfg_wr && (paddr[5:3] == REG_COEF_WRITE)
                     && ({2'b00, pwdata[37:32]} < 8'(COEF_COUNT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_reg <= 4'd1;
            wl_reg <= 13'd4096;
            as_reg <= 32'd65536;
            cs_reg <= CH_A;
            cw_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                REG_SECTION_COUNT:  sc_reg <= pwdata[3:0];
                REG_WINDOW_LENGTH:  wl_reg <= pwdata[12:0];
                REG_AREA_SCALE:     as_reg <= pwdata[31:0];
                REG_CHANNEL_SELECT: cs_reg <= pwdata[1:0];
                REG_COEF_WRITE:     cw_reg <= pwdata[37:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_SECTION_COUNT:  prdata = 64'(sc_reg);
            REG_WINDOW_LENGTH:  prdata = 64'(wl_reg);
            REG_AREA_SCALE:     prdata = 64'(as_reg);
            REG_CHANNEL_SELECT: prdata = 64'(cs_reg);
            REG_COEF_WRITE:     prdata = 64'(cw_reg);
            default:            prdata = '0;
        endcase
    end

    // coefficient memory with valid bits
    logic [31:0]           coef_mem [COEF_COUNT];
    logic [COEF_COUNT-1:0] coef_vld_reg;
    logic [31:0]           coef_q_reg;
    logic                  coef_vq_reg;
    logic [CIDX_W-1:0]     coef_raddr;
    logic signed [31:0]    coef_val;

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[CIDX_W'(pwdata[37:32])] <= pwdata[31:0];
        end
        coef_q_reg <= coef_mem[coef_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_vld_reg <= '0;
            coef_vq_reg  <= 1'b0;
        end else begin
            if (coef_we) begin
                coef_vld_reg[CIDX_W'(pwdata[37:32])] <= 1'b1;
            end
            coef_vq_reg <= coef_vld_reg[coef_raddr];
        end
    end

    assign coef_val = coef_vq_reg ? $signed(coef_q_reg) : 32'sd0;

    // window store
    logic [Y_W-1:0]    store_mem [WINDOW_MAX];
    logic [Y_W-1:0]    store_q_reg;
    logic              st_we;
    logic [WIDX_W-1:0] st_raddr;

    // datapath state
    state_t                    state_reg, state_next;
    divop_t                    op_reg, op_next;
    logic [SEC_W-1:0]          sec_reg, sec_next;
    logic signed [31:0]        x_reg, x_next;
    logic signed [31:0]        y_reg, y_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [31:0]        z0_reg [MAX_SECTIONS];
    logic signed [31:0]        z0_next [MAX_SECTIONS];
    logic signed [31:0]        z1_reg [MAX_SECTIONS];
    logic signed [31:0]        z1_next [MAX_SECTIONS];
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [A_W-1:0]            abs_reg, abs_next;
    logic [31:0]               wcnt_reg, wcnt_next;
    logic [CNT_W-1:0]          i_reg, i_next;
    logic signed [MEAN_W-1:0]  mean_reg, mean_next;
    logic [S2_W-1:0]           s2_reg, s2_next;
    logic [M4_W-1:0]           m4_reg, m4_next;
    logic [47:0]               m2a_reg, m2a_next;
    logic [63:0]               m4a_reg, m4a_next;
    logic [DQ_W-1:0]           dq_reg, dq_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic [DCNT_W-1:0]         dcnt_reg, dcnt_next;
    logic                      neg_reg, neg_next;
    logic [AR_W-1:0]           aacc_reg, aacc_next;
    logic [39:0]               area_reg, area_next;
    logic [23:0]               kurt_reg, kurt_next;
    logic                      flat_reg, flat_next;
    logic                      mv_reg, mv_next;
    logic [31:0]               mwn_reg, mwn_next;
    logic [39:0]               marea_reg, marea_next;
    logic [23:0]               mkurt_reg, mkurt_next;
    logic                      mflat_reg, mflat_next;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod_reg;

    // helpers
    logic signed [16:0]        pick;
    logic signed [31:0]        x_in;
    logic [SEC_W-1:0]          sc_eff;
    logic [CNT_W-1:0]          len_eff;
    logic [SIDX_W-1:0]         sidx;
    logic [SEC_W-1:0]          sec_inc;
    logic                      sec_last;
    logic [CIDX_W-1:0]         coef_base, coef_base_nx;
    logic signed [ACC_W-1:0]   pval;
    logic signed [Y_W-1:0]     yo;
    logic [Y_W-1:0]            yabs;
    logic                      closing;
    logic [SUM_W-1:0]          sum_mag;
    logic signed [D_W-1:0]     d_val;
    logic [REM_W-1:0]          rem_sh;
    logic                      div_ge;
    logic [AR_W-1:0]           ar_sum;
    logic signed [MEAN_W-1:0]  mean_q;

    always_comb begin
        case (cs_reg)
            CH_A:    pick = 17'(s_sample_a);
            CH_B:    pick = 17'(s_sample_b);
            default: pick = 17'(s_sample_a) - 17'(s_sample_b);
        endcase
    end

    assign x_in = {{7{pick[16]}}, pick, 8'b0};

    assign sc_eff = (sc_reg == 4'd0) ? SEC_W'(1) :
                    (({1'b0, sc_reg}) > 5'(MAX_SECTIONS)) ? SEC_W'(MAX_SECTIONS) :
                    SEC_W'(sc_reg);
    assign len_eff = (wl_reg == 13'd0) ? CNT_W'(1) :
                     (LC_W'(wl_reg) > LC_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) :
                     CNT_W'(wl_reg);

    assign sidx         = sec_reg[SIDX_W-1:0];
    assign sec_inc      = sec_reg + SEC_W'(1);
    assign sec_last     = (sec_inc == sc_eff);
    assign coef_base    = CIDX_W'({sec_reg, 2'b00}) + CIDX_W'(sec_reg);
    assign coef_base_nx = CIDX_W'({sec_inc, 2'b00}) + CIDX_W'(sec_inc);
    assign pval         = ACC_W'(prod_reg >>> COEF_FRAC);

    always_comb begin
        if (x_reg > 32'sd8388607) begin
            yo = 24'sh7F_FFFF;
        end else if (x_reg < -32'sd8388608) begin
            yo = 24'sh80_0000;
        end else begin
            yo = x_reg[23:0];
        end
    end

    assign yabs    = yo[Y_W-1] ? 24'(-yo) : 24'(yo);
    assign closing = (LC_W'(fill_reg) + LC_W'(1)) >= LC_W'(len_eff);
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign d_val   = D_W'($signed(store_q_reg)) - D_W'(mean_reg);
    assign rem_sh  = {rem_reg[REM_W-2:0], dq_reg[DQ_W-1]};
    assign div_ge  = rem_sh >= {1'b0, den_reg};
    assign ar_sum  = AR_W'(prod_reg[A_W+15:0]) + aacc_reg;
    assign mean_q  = MEAN_W'(dq_reg[Y_W-1:0]);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        sec_next   = sec_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        z0_next    = z0_reg;
        z1_next    = z1_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        abs_next   = abs_reg;
        wcnt_next  = wcnt_reg;
        i_next     = i_reg;
        mean_next  = mean_reg;
        s2_next    = s2_reg;
        m4_next    = m4_reg;
        m2a_next   = m2a_reg;
        m4a_next   = m4a_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        aacc_next  = aacc_reg;
        area_next  = area_reg;
        kurt_next  = kurt_reg;
        flat_next  = flat_reg;
        mwn_next   = mwn_reg;
        marea_next = marea_reg;
        mkurt_next = mkurt_reg;
        mflat_next = mflat_reg;
        mv_next    = (mv_reg && m_ready) ? 1'b0 : mv_reg;
        mul_a      = '0;
        mul_b      = '0;
        coef_raddr = coef_base;
        st_we      = 1'b0;
        st_raddr   = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = x_in;
                    sec_next   = '0;
                    state_next = ST_C_RD0;
                end
            end
            ST_C_RD0: begin
                coef_raddr = coef_base + CIDX_W'(TERM_B0);
                state_next = ST_C_M0;
            end
            ST_C_M0: begin
                mul_a      = MUL_W'(coef_val);
                mul_b      = MUL_W'(x_reg);
                coef_raddr = coef_base + CIDX_W'(TERM_B1);
                state_next = ST_C_Y;
            end
            ST_C_Y: begin
                y_next     = sat32(pval + ACC_W'(z0_reg[sidx]));
                mul_a      = MUL_W'(coef_val);
                mul_b      = MUL_W'(x_reg);
                coef_raddr = coef_base + CIDX_W'(TERM_A1);
                state_next = ST_C_T1;
            end
            ST_C_T1: begin
                acc_next   = pval;
                mul_a      = MUL_W'(coef_val);
                mul_b      = MUL_W'(y_reg);
                coef_raddr = coef_base + CIDX_W'(TERM_B2);
                state_next = ST_C_T2;
            end
            ST_C_T2: begin
                acc_next   = acc_reg - pval;
                mul_a      = MUL_W'(coef_val);
                mul_b      = MUL_W'(x_reg);
                coef_raddr = coef_base + CIDX_W'(TERM_A2);
                state_next = ST_C_T3;
            end
            ST_C_T3: begin
                z0_next[sidx] = sat32(acc_reg + ACC_W'(z1_reg[sidx]));
                acc_next      = pval;
                mul_a         = MUL_W'(coef_val);
                mul_b         = MUL_W'(y_reg);
                state_next    = ST_C_T4;
            end
            ST_C_T4: begin
                z1_next[sidx] = sat32(acc_reg - pval);
                x_next        = y_reg;
                if (sec_last) begin
                    state_next = ST_C_OUT;
                end else begin
                    sec_next   = sec_inc;
                    coef_raddr = coef_base_nx + CIDX_W'(TERM_B0);
                    state_next = ST_C_M0;
                end
            end
            ST_C_OUT: begin
                st_we     = 1'b1;
                fill_next = fill_reg + CNT_W'(1);
                sum_next  = sum_reg + SUM_W'(yo);
                abs_next  = abs_reg + A_W'(yabs);
                state_next = closing ? ST_W_AREA0 : ST_IDLE;
            end
            ST_W_AREA0: begin
                mul_a      = MUL_W'(abs_reg);
                mul_b      = MUL_W'(as_reg[15:0]);
                state_next = ST_W_AREA1;
            end
            ST_W_AREA1: begin
                aacc_next  = AR_W'(prod_reg[A_W+15:16]);
                mul_a      = MUL_W'(abs_reg);
                mul_b      = MUL_W'(as_reg[31:16]);
                state_next = ST_W_AREA2;
            end
            ST_W_AREA2: begin
                area_next  = ((ar_sum >> 16) > AR_W'(AREA_MAX)) ? AREA_MAX : 40'(ar_sum >> 16);
                neg_next   = sum_reg[SUM_W-1];
                dq_next    = DQ_W'(sum_mag);
                rem_next   = '0;
                den_next   = DEN_W'(fill_reg);
                dcnt_next  = DCNT_W'(DQ_W);
                op_next    = OP_MEAN;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next  = div_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                dq_next   = {dq_reg[DQ_W-2:0], div_ge};
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1)) begin
                    state_next = ST_DIV_END;
                end
            end
            ST_DIV_END: begin
                unique case (op_reg)
                    OP_MEAN: begin
                        mean_next  = neg_reg ? -(mean_q + MEAN_W'(|rem_reg)) : mean_q;
                        i_next     = '0;
                        s2_next    = '0;
                        m4_next    = '0;
                        st_raddr   = '0;
                        state_next = ST_P_D;
                    end
                    OP_M2: begin
                        m2a_next   = dq_reg[47:0];
                        dq_next    = DQ_W'(m4_reg);
                        rem_next   = '0;
                        dcnt_next  = DCNT_W'(DQ_W);
                        op_next    = OP_M4;
                        state_next = ST_DIV;
                    end
                    OP_M4: begin
                        m4a_next = dq_reg[63:0];
                        if (m2a_reg == 48'd0) begin
                            kurt_next  = '0;
                            state_next = ST_W_DONE;
                        end else begin
                            state_next = ST_K_SQ0;
                        end
                    end
                    OP_KURT: begin
                        kurt_next  = (|dq_reg[DQ_W-1:24]) ? KURT_MAX : dq_reg[23:0];
                        state_next = ST_W_DONE;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_P_D: begin
                mul_a      = MUL_W'(d_val);
                mul_b      = MUL_W'(d_val);
                state_next = ST_P_E;
            end
            ST_P_E: begin
                s2_next    = s2_reg + S2_W'(prod_reg[47:0]);
                mul_a      = MUL_W'(prod_reg[47:16]);
                mul_b      = MUL_W'(prod_reg[47:16]);
                state_next = ST_P_M;
            end
            ST_P_M: begin
                m4_next = m4_reg + M4_W'(prod_reg[63:0]);
                if ((i_reg + CNT_W'(1)) == fill_reg) begin
                    if (s2_reg == '0) begin
                        flat_next  = 1'b1;
                        kurt_next  = '0;
                        state_next = ST_W_DONE;
                    end else begin
                        flat_next  = 1'b0;
                        dq_next    = DQ_W'(s2_reg);
                        rem_next   = '0;
                        dcnt_next  = DCNT_W'(DQ_W);
                        op_next    = OP_M2;
                        state_next = ST_DIV;
                    end
                end else begin
                    i_next     = i_reg + CNT_W'(1);
                    st_raddr   = WIDX_W'(i_reg + CNT_W'(1));
                    state_next = ST_P_D;
                end
            end
            ST_K_SQ0: begin
                mul_a      = MUL_W'(m2a_reg[23:0]);
                mul_b      = MUL_W'(m2a_reg[23:0]);
                state_next = ST_K_SQ1;
            end
            ST_K_SQ1: begin
                den_next   = DEN_W'(prod_reg[47:0]);
                mul_a      = MUL_W'(m2a_reg[47:24]);
                mul_b      = MUL_W'(m2a_reg[23:0]);
                state_next = ST_K_SQ2;
            end
            ST_K_SQ2: begin
                den_next   = den_reg + (DEN_W'(prod_reg[47:0]) << 25);
                mul_a      = MUL_W'(m2a_reg[47:24]);
                mul_b      = MUL_W'(m2a_reg[47:24]);
                state_next = ST_K_SQ3;
            end
            ST_K_SQ3: begin
                den_next   = den_reg + (DEN_W'(prod_reg[47:0]) << 48);
                dq_next    = {m4a_reg, 48'd0};
                rem_next   = '0;
                dcnt_next  = DCNT_W'(DQ_W);
                op_next    = OP_KURT;
                state_next = ST_DIV;
            end
            ST_W_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mwn_next   = wcnt_reg;
                    marea_next = area_reg;
                    mkurt_next = kurt_reg;
                    mflat_next = flat_reg;
                    wcnt_next  = wcnt_reg + 32'd1;
                    fill_next  = '0;
                    sum_next   = '0;
                    abs_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_MEAN;
            sec_reg   <= '0;
            z0_reg    <= '{default: '0};
            z1_reg    <= '{default: '0};
            fill_reg  <= '0;
            sum_reg   <= '0;
            abs_reg   <= '0;
            wcnt_reg  <= '0;
            i_reg     <= '0;
            dcnt_reg  <= '0;
            flat_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            sec_reg   <= sec_next;
            z0_reg    <= z0_next;
            z1_reg    <= z1_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            abs_reg   <= abs_next;
            wcnt_reg  <= wcnt_next;
            i_reg     <= i_next;
            dcnt_reg  <= dcnt_next;
            flat_reg  <= flat_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        mean_reg  <= mean_next;
        s2_reg    <= s2_next;
        m4_reg    <= m4_next;
        m2a_reg   <= m2a_next;
        m4a_reg   <= m4a_next;
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        aacc_reg  <= aacc_next;
        area_reg  <= area_next;
        kurt_reg  <= kurt_next;
        mwn_reg   <= mwn_next;
        marea_reg <= marea_next;
        mkurt_reg <= mkurt_next;
        mflat_reg <= mflat_next;
        prod_reg  <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[fill_reg[WIDX_W-1:0]] <= yo;
        end
        store_q_reg <= store_mem[st_raddr];
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = mv_reg;
    assign m_window_number = mwn_reg;
    assign m_area          = marea_reg;
    assign m_kurtosis      = mkurt_reg;
    assign m_flat_window   = mflat_reg;

    `BWAK_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE), "not idle after reset")
    `BWAK_ASSERT_CLK(a_accept_starts, (s_valid && s_ready) |=> (state_reg == ST_C_RD0), "beat lost")
    `BWAK_ASSERT_CLK(a_result_src, $rose(m_valid) |-> ($past(state_reg) == ST_W_DONE), "stray beat")
    `BWAK_ASSERT_CLK(a_fill_bound, fill_reg <= CNT_W'(WINDOW_MAX), "fill count overrun")

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for the band-pass window area and kurtosis block, checked against a built-in predictor
`default_nettype none
module tb_top
    import bwak_pkg::*;
();

    localparam logic [2:0] REG_SPARE   = 3'd5;
    localparam logic [1:0] CH_DIFF     = 2'd2;
    localparam logic [1:0] CH_DIFF_ALT = 2'd3;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 300;
    localparam int STORE_DEPTH = 4096;
    localparam int NUM_SECT    = 8;

    typedef struct packed {
        logic [31:0] number;
        logic [39:0] area;
        logic [23:0] kurt;
        logic        flat;
    } window_t;

    typedef enum logic { ROW_REG, ROW_BEAT } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [2:0]         idx;
        logic [63:0]        data;
        logic signed [15:0] a;
        logic signed [15:0] b;
        bit                 hand;
        window_t            want;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_sample_a = '0;
    logic signed [15:0] s_sample_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [31:0]        m_window_number;
    logic [39:0]        m_area;
    logic [23:0]        m_kurtosis;
    logic               m_flat_window;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [5:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;

    bandpass_window_area_kurtosis u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_a      (s_sample_a),
        .s_sample_b      (s_sample_b),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_window_number (m_window_number),
        .m_area          (m_area),
        .m_kurtosis      (m_kurtosis),
        .m_flat_window   (m_flat_window),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #4 aclk = ~aclk;

    // predictor state
    int                 coef [5*NUM_SECT];
    int                 delays [2*NUM_SECT];
    int                 samples [STORE_DEPTH];
    longint             run_sum;
    longint unsigned    run_abs;
    int unsigned        fill;
    logic [31:0]        win_count;
    logic [3:0]         sec_cnt;
    logic [12:0]        win_len;
    logic [31:0]        scale;
    logic [1:0]         chan;

    window_t            windows_due [$];
    row_t               plan [$];
    int                 mismatches;
    int                 cycles;
    int                 hold_left;
    bit                 calm;
    window_t            got;

    function automatic longint coef_prod(input int c, input longint v);
        return (longint'(c) * v) >>> 29;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void reg_update(input logic [2:0] idx, input logic [63:0] data);
        case (idx)
            REG_SECTION_COUNT:  sec_cnt = data[3:0];
            REG_WINDOW_LENGTH:  win_len = data[12:0];
            REG_AREA_SCALE:     scale = data[31:0];
            REG_CHANNEL_SELECT: chan = data[1:0];
            REG_COEF_WRITE: begin
                if (data[37:32] < 5*NUM_SECT) coef[data[37:32]] = int'(data[31:0]);
            end
            default: ;
        endcase
    endfunction

    // filters one sample pair and closes the window when it is full
    function automatic bit window_step(input logic signed [15:0] a, input logic signed [15:0] b,
                                       output window_t w);
        longint          pick, x, y, z1, z2, mean, d, nl;
        longint unsigned d2, e, m2a, m4a, area, lo16, hi16;
        logic [127:0]    s2, m4, num, den, q;
        int unsigned     len, cnt, n;
        w = '0;
        len = (win_len == 0) ? 1 : win_len;
        if (len > STORE_DEPTH) len = STORE_DEPTH;
        case (chan)
            CH_A:    pick = a;
            CH_B:    pick = b;
            default: pick = longint'(a) - longint'(b);
        endcase
        cnt = (sec_cnt == 0) ? 1 : sec_cnt;
        if (cnt > NUM_SECT) cnt = NUM_SECT;
        x = pick * 256;
        for (int s = 0; s < cnt; s++) begin
            y  = clip(coef_prod(coef[5*s], x) + delays[2*s],
                      -64'sd2147483648, 64'sd2147483647);
            z1 = coef_prod(coef[5*s+1], x) - coef_prod(coef[5*s+3], y) + delays[2*s+1];
            z2 = coef_prod(coef[5*s+2], x) - coef_prod(coef[5*s+4], y);
            delays[2*s]   = int'(clip(z1, -64'sd2147483648, 64'sd2147483647));
            delays[2*s+1] = int'(clip(z2, -64'sd2147483648, 64'sd2147483647));
            x = y;
        end
        y = clip(x, -64'sd8388608, 64'sd8388607);
        if (fill < STORE_DEPTH) samples[fill] = int'(y);
        fill++;
        run_sum += y;
        run_abs += (y < 0) ? -y : y;
        if (fill < len) return 1'b0;

        n  = fill;
        nl = longint'(n);
        if (run_sum >= 0) mean = run_sum / nl;
        else mean = -((-run_sum + nl - 1) / nl);
        s2 = '0;
        m4 = '0;
        for (int i = 0; i < n; i++) begin
            d  = longint'(samples[i]) - mean;
            d2 = d * d;
            e  = d2 >> 16;
            s2 += d2;
            m4 += e * e;
        end
        w.flat = (s2 == 0);
        m2a = 64'(s2 / n);
        m4a = 64'(m4 / n);
        if (w.flat || m2a == 0) begin
            w.kurt = '0;
        end else begin
            num = {64'd0, m4a} << 48;
            den = m2a * m2a;
            q = num / den;
            w.kurt = (q > KURT_MAX) ? KURT_MAX : q[23:0];
        end
        lo16 = scale[15:0];
        hi16 = scale[31:16];
        area = (run_abs * hi16 + ((run_abs * lo16) >> 16)) >> 16;
        w.area = (area > AREA_MAX) ? AREA_MAX : area[39:0];
        w.number = win_count;
        win_count++;
        fill = 0;
        run_sum = 0;
        run_abs = 0;
        return 1'b1;
    endfunction

    function automatic void add_reg(input logic [2:0] idx, input logic [63:0] data);
        row_t r;
        r = '{ROW_REG, idx, data, '0, '0, 1'b0, '0};
        plan.push_back(r);
    endfunction

    function automatic void add_beat(input logic signed [15:0] a, input logic signed [15:0] b);
        row_t r;
        r = '{ROW_BEAT, '0, '0, a, b, 1'b0, '0};
        plan.push_back(r);
    endfunction

    // zero coefficients give a flat window with zero area
    function automatic void add_hand(input logic signed [15:0] a, input logic signed [15:0] b,
                                     input logic [31:0] number);
        row_t r;
        r = '{ROW_BEAT, '0, '0, a, b, 1'b1, '{number, 40'd0, 24'd0, 1'b1}};
        plan.push_back(r);
    endfunction

    function automatic logic [63:0] coef_word(input int idx, input logic [31:0] v);
        return {26'd0, 6'(idx), v};
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        reg_update(idx, data);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic push_beat(input logic signed [15:0] a, input logic signed [15:0] b,
                             input bit hand, input window_t want);
        window_t w;
        while (!calm && $urandom_range(99) < 19) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_sample_a = a;
        s_sample_b = b;
        do @(posedge aclk); while (!s_ready);
        if (window_step(a, b, w)) windows_due.push_back(hand ? want : w);
        @(negedge aclk);
    endtask

    task automatic quiesce();
        s_valid = 1'b0;
        while (windows_due.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic load_coefficients();
        int style;
        for (int s = 0; s < NUM_SECT; s++) begin
            style = $urandom_range(7);
            for (int t = 0; t < 5; t++) begin
                logic [31:0] v;
                case (style)
                    0, 1, 2: v = (t == 0) ? 32'($urandom_range(32'h2000_0000, 32'h0800_0000)) : '0;
                    3, 4, 5: begin
                        case (t)
                            0:       v = 32'($urandom_range(32'h0800_0000));
                            2:       v = -32'($urandom_range(32'h0800_0000));
                            3:       v = -32'($urandom_range(32'h2000_0000));
                            4:       v = 32'($urandom_range(32'h1000_0000));
                            default: v = '0;
                        endcase
                    end
                    default: v = $urandom;
                endcase
                reg_write(REG_COEF_WRITE, coef_word(5*s + t, v));
            end
        end
    endtask

    // receiver side
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = calm || ($urandom_range(99) >= 19);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (windows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: window %0d area %0h kurt %0h flat %0b",
                             m_window_number, m_area, m_kurtosis, m_flat_window);
            end else begin
                got = windows_due.pop_front();
                if (m_window_number !== got.number || m_area !== got.area ||
                    m_kurtosis !== got.kurt || m_flat_window !== got.flat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0h %0h %0b, got %0d %0h %0h %0b",
                                 got.number, got.area, got.kurt, got.flat,
                                 m_window_number, m_area, m_kurtosis, m_flat_window);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        int items;
        int pick;
        run_sum = 0;
        run_abs = 0;
        fill = 0;
        win_count = '0;
        sec_cnt = 4'd1;
        win_len = 13'd4096;
        scale = 32'd65536;
        chan = CH_A;
        mismatches = 0;
        cycles = 0;
        hold_left = 0;
        calm = 1'b0;

        add_reg(REG_WINDOW_LENGTH, 64'd1);
        add_hand(16'sh7FFF, -16'sh8000, 32'd0);
        add_hand(-16'sh8000, 16'sh7FFF, 32'd1);
        add_hand(16'sd0, 16'sd0, 32'd2);
        add_hand(-16'sd1, 16'sd1, 32'd3);
        add_reg(REG_COEF_WRITE, coef_word(0, 32'h2000_0000));
        add_reg(REG_AREA_SCALE, 64'hFFFF_FFFF);
        add_reg(REG_WINDOW_LENGTH, 64'd2);
        add_beat(16'sh7FFF, 16'sd0);
        add_beat(-16'sh8000, 16'sd0);
        add_reg(REG_CHANNEL_SELECT, 64'(CH_B));
        add_beat(16'sd0, 16'sh7FFF);
        add_beat(16'sd0, -16'sh8000);
        add_reg(REG_CHANNEL_SELECT, 64'(CH_DIFF));
        add_beat(16'sh7FFF, -16'sh8000);
        add_beat(-16'sh8000, 16'sh7FFF);
        add_reg(REG_CHANNEL_SELECT, 64'(CH_DIFF_ALT));
        add_beat(16'sd100, -16'sd100);
        add_beat(16'sd5, 16'sd5);
        add_reg(REG_SECTION_COUNT, 64'd0);
        add_reg(REG_WINDOW_LENGTH, 64'd0);
        add_beat(-16'sd1234, 16'sd0);
        add_reg(REG_SECTION_COUNT, 64'd15);
        add_reg(REG_COEF_WRITE, coef_word(40, 32'h1234_5678));
        add_reg(REG_COEF_WRITE, coef_word(63, 32'hFFFF_FFFF));
        add_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
        add_reg(REG_AREA_SCALE, 64'd0);
        add_beat(16'sd77, 16'sd0);
        // tiny variance: samples 0, 0, -1
        add_reg(REG_SECTION_COUNT, 64'd1);
        add_reg(REG_CHANNEL_SELECT, 64'(CH_A));
        add_reg(REG_COEF_WRITE, coef_word(0, 32'd1));
        add_reg(REG_AREA_SCALE, 64'd65536);
        add_reg(REG_WINDOW_LENGTH, 64'd3);
        add_beat(16'sd0, 16'sd0);
        add_beat(16'sd0, 16'sd0);
        add_beat(-16'sd1, 16'sd0);
        // window shortened while partly filled
        add_reg(REG_COEF_WRITE, coef_word(0, 32'h1000_0000));
        add_reg(REG_WINDOW_LENGTH, 64'd8);
        add_beat(16'sd300, 16'sd0);
        add_beat(-16'sd9000, 16'sd0);
        add_beat(16'sd4444, 16'sd0);
        add_reg(REG_WINDOW_LENGTH, 64'd2);
        add_beat(16'sd12, 16'sd0);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                quiesce();
                reg_write(plan[i].idx, plan[i].data);
            end else begin
                push_beat(plan[i].a, plan[i].b, plan[i].hand, plan[i].want);
            end
        end
        quiesce();

        for (int ph = 0; ph < 16; ph++) begin
            calm = (ph == 4);
            reg_write(REG_SECTION_COUNT, 64'($urandom_range(15)));
            pick = $urandom_range(9);
            if (ph == 7) reg_write(REG_WINDOW_LENGTH, 64'd1);
            else if (pick == 0) reg_write(REG_WINDOW_LENGTH, 64'd0);
            else if (pick == 1) reg_write(REG_WINDOW_LENGTH, 64'($urandom_range(300, 100)));
            else reg_write(REG_WINDOW_LENGTH, 64'($urandom_range(40, 1)));
            pick = $urandom_range(4);
            if (pick == 0) reg_write(REG_AREA_SCALE, 64'd0);
            else if (pick == 1) reg_write(REG_AREA_SCALE, 64'hFFFF_FFFF);
            else reg_write(REG_AREA_SCALE, 64'($urandom));
            reg_write(REG_CHANNEL_SELECT, 64'($urandom_range(3)));
            load_coefficients();
            reg_write(REG_COEF_WRITE, coef_word($urandom_range(63, 40), $urandom));
            reg_write(REG_SPARE + 3'($urandom_range(2)), {$urandom, $urandom});
            if (ph == 7) hold_left = 3000;
            items = $urandom_range(40, 25);
            for (int k = 0; k < items; k++)
                push_beat(16'($urandom), 16'($urandom), 1'b0, '0);
            quiesce();
        end

        // length beyond the store, then closed early by a shorter length
        calm = 1'b0;
        reg_write(REG_SECTION_COUNT, 64'd1);
        reg_write(REG_WINDOW_LENGTH, 64'd8191);
        reg_write(REG_AREA_SCALE, 64'hFFFF_FFFF);
        reg_write(REG_CHANNEL_SELECT, 64'(CH_A));
        reg_write(REG_COEF_WRITE, coef_word(0, 32'h2000_0000));
        for (int t = 1; t < 5; t++) reg_write(REG_COEF_WRITE, coef_word(t, 32'd0));
        for (int k = 0; k < 150; k++)
            push_beat(16'($urandom), 16'($urandom), 1'b0, '0);
        quiesce();
        reg_write(REG_WINDOW_LENGTH, 64'd1);
        push_beat(16'($urandom), 16'($urandom), 1'b0, '0);
        quiesce();

        if (mismatches == 0 && windows_due.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
